>>> rtl/cmmt_pkg.sv
// Shared constants, types and command/status structures of the cluster mode merge table.
`default_nettype none
package cmmt_pkg;

    localparam int MAX_MODES = 64;
    localparam int NUM_DIMS  = 3;
    localparam int COORD_W   = 16;
    localparam int IDX_W     = $clog2(MAX_MODES);
    localparam int CNT_W     = $clog2(MAX_MODES + 1);
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + $clog2(NUM_DIMS + 1);
    localparam int RAD_W     = 16;
    localparam int LIM_W     = 2 * RAD_W;
    localparam int ENTRY_W   = NUM_DIMS * COORD_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MODES);

    typedef logic [NUM_DIMS-1:0][COORD_W-1:0] t_point;

    typedef struct packed {
        logic             capture;
        logic             issue;
        logic [IDX_W-1:0] addr;
        logic             flush;
        logic             fin_hit;
        logic             fin_miss;
        logic             fin_new;
        logic [CNT_W-1:0] count;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic busy;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/cluster_mode_merge_table_unit.sv
// Top level of the cluster mode merge table: stream ports, register port and submodules.
//
// A point enters on the s_axis channel (three signed Q8.8 coordinates in tdata). The block
// compares it in index order against every stored mode, one mode per cycle through a
// three-stage read/square/compare pipeline, and stops at the first mode within the merge
// radius. Without a match the point is appended as a new mode, or, with all 64 entries in
// use, returned unchanged with table_full set. One result transaction leaves on m_axis
// for every input transaction.
// Without a match an item reaches the result register once all N stored modes have been
// read and compared, N being the number of modes stored; a match at index k gets there
// once mode k has been compared. The output register is loaded after that, and the next
// item can be accepted only once it is loaded; the single memory read port, one entry per
// cycle, sets how long a scan lasts. One item is processed at a time.
// The merge radius is written through the APB port at address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the mode count, restores the radius to 0.5 and empties the output register;
// the memory contents need no clearing. While the receiver stalls, the result stays in the
// output register and the next item may be accepted and scanned, waiting at the end; the
// input is then held off until the output register frees.
`default_nettype none
module cluster_mode_merge_table_unit
    import cmmt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // coord_0 [15:0], coord_1 [31:16], coord_2 [47:32]
    input  wire  [47:0] s_axis_tdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // mode_0 [15:0], mode_1 [31:16], mode_2 [47:32], cluster_index [53:48],
    // modes_in_use [60:54], zero [63:61]
    output logic [63:0] m_axis_tdata,
    // created_new [0], table_full [1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_RADIUS = 1'b0;

    logic [RAD_W-1:0] r_radius;
    t_cmd             cmd;
    t_sts             sts;
    t_point           in_point;
    t_point           out_mode;
    logic [IDX_W-1:0] out_idx;
    logic             out_new;
    logic             out_full;
    logic [CNT_W-1:0] out_cnt;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(128);
        end else if (psel && penable && pwrite && (paddr[2] == REG_RADIUS)) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(r_radius) : 32'd0;

    assign in_point = s_axis_tdata;

    cmmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cmmt_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_point   (in_point),
        .i_radius  (r_radius),
        .o_sts     (sts),
        .o_mode    (out_mode),
        .o_index   (out_idx),
        .o_created (out_new),
        .o_full    (out_full),
        .o_count   (out_cnt)
    );

    assign m_axis_tdata = {3'b000, out_cnt, out_idx, out_mode};
    assign m_axis_tuser = {out_full, out_new};

endmodule
`default_nettype wire

>>> rtl/cmmt_ctrl.sv
// Controller: transaction handshakes, scan address sequencing and mode count.
`default_nettype none
module cmmt_ctrl
    import cmmt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_vld, n_out_vld;
    logic             out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_count  = r_count;
        o_cmd    = '0;
        o_cmd.addr  = r_addr[IDX_W-1:0];
        o_cmd.count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_addr  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    // Entries still in flight behind the first match are discarded.
                    o_cmd.fin_hit = 1'b1;
                    o_cmd.flush   = 1'b1;
                    n_state       = S_DONE;
                end else if (r_addr < r_count) begin
                    o_cmd.issue = 1'b1;
                    n_addr      = r_addr + 1'b1;
                end else if (!i_sts.busy) begin
                    o_cmd.fin_miss = 1'b1;
                    if (r_count < MAX_CNT) begin
                        o_cmd.fin_new = 1'b1;
                        o_cmd.addr    = r_count[IDX_W-1:0];
                        n_count       = r_count + 1'b1;
                    end
                    o_cmd.count = n_count;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_vld = o_cmd.load_out || (r_out_vld && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cmmt_dp.sv
// Datapath: mode memory, distance pipeline, result and output registers.
`default_nettype none
module cmmt_dp
    import cmmt_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cmd             i_cmd,
    input  t_point           i_point,
    input  wire [RAD_W-1:0]  i_radius,
    output t_sts             o_sts,
    output t_point           o_mode,
    output logic [IDX_W-1:0] o_index,
    output logic             o_created,
    output logic             o_full,
    output logic [CNT_W-1:0] o_count
);

    logic [ENTRY_W-1:0] mem [MAX_MODES];

    t_point             r_point;
    logic [LIM_W-1:0]   r_limit;
    t_point             r_rd;
    logic               r_s1_vld;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [NUM_DIMS-1:0][SQ_W-1:0] r_sq;
    t_point             r_s2_data;
    logic               r_s2_vld;
    logic [IDX_W-1:0]   r_s2_idx;

    t_point             r_res_mode;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_res_new;
    logic               r_res_full;
    logic [CNT_W-1:0]   r_res_cnt;

    t_point             r_out_mode;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_new;
    logic               r_out_full;
    logic [CNT_W-1:0]   r_out_cnt;

    logic [NUM_DIMS-1:0][COORD_W-1:0] mag;
    logic [SUM_W-1:0]   sq_dist;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        for (int d = 0; d < NUM_DIMS; d++) begin
            diff = $signed({r_point[d][COORD_W-1], r_point[d]})
                 - $signed({r_rd[d][COORD_W-1], r_rd[d]});
            if (diff[DIFF_W-1]) begin
                mag[d] = COORD_W'(-diff);
            end else begin
                mag[d] = diff[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        sq_dist = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            sq_dist = sq_dist + SUM_W'(r_sq[d]);
        end
    end

    assign o_sts.hit  = r_s2_vld && (sq_dist <= SUM_W'(r_limit));
    assign o_sts.busy = r_s1_vld || r_s2_vld;

    // Memory: one write port for new modes, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_new) begin
            mem[i_cmd.addr] <= r_point;
        end
        r_rd <= mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld && !i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= i_radius * i_radius;
        if (i_cmd.capture) begin
            r_point <= i_point;
        end
        r_s1_idx <= i_cmd.addr;
        for (int d = 0; d < NUM_DIMS; d++) begin
            r_sq[d] <= mag[d] * mag[d];
        end
        r_s2_data <= r_rd;
        r_s2_idx  <= r_s1_idx;

        if (i_cmd.fin_hit) begin
            r_res_mode <= r_s2_data;
            r_res_idx  <= r_s2_idx;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
            r_res_cnt  <= i_cmd.count;
        end else if (i_cmd.fin_miss) begin
            r_res_mode <= r_point;
            r_res_idx  <= i_cmd.fin_new ? i_cmd.addr : '0;
            r_res_new  <= i_cmd.fin_new;
            r_res_full <= !i_cmd.fin_new;
            r_res_cnt  <= i_cmd.count;
        end

        if (i_cmd.load_out) begin
            r_out_mode <= r_res_mode;
            r_out_idx  <= r_res_idx;
            r_out_new  <= r_res_new;
            r_out_full <= r_res_full;
            r_out_cnt  <= r_res_cnt;
        end
    end

    assign o_mode    = r_out_mode;
    assign o_index   = r_out_idx;
    assign o_created = r_out_new;
    assign o_full    = r_out_full;
    assign o_count   = r_out_cnt;

endmodule
`default_nettype wire

>>> tb/sv/cmmt_merge_checker.sv
// Checker for the cluster mode merge table: tracks the mode table and compares every result.
module cmmt_merge_checker
    import cmmt_pkg::*;
#(
    parameter logic [2:0] RADIUS_ADDR = 3'd0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // coord_0 [15:0], coord_1 [31:16], coord_2 [47:32]
    input  wire  [47:0] s_axis_tdata,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    // mode_0 [15:0], mode_1 [31:16], mode_2 [47:32], cluster_index [53:48],
    // modes_in_use [60:54], zero [63:61]
    input  wire  [63:0] m_axis_tdata,
    // created_new [0], table_full [1]
    input  wire  [1:0]  m_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam logic [RAD_W-1:0] RESET_RADIUS = RAD_W'(128);

    typedef struct packed {
        t_point           mode;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] in_use;
        logic             created;
        logic             full;
    } t_merge_result;

    logic [RAD_W-1:0] radius_q;
    t_point           modes_q [MAX_MODES];
    int unsigned      count_q;
    t_merge_result    expected_results [$];

    initial o_fail_count = 0;
    initial o_outstanding = 0;

    function automatic longint unsigned dist_sq(input t_point a, input t_point b);
        longint unsigned acc;
        longint          diff;
        acc = 0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            diff = longint'($signed(a[k])) - longint'($signed(b[k]));
            acc += diff * diff;
        end
        return acc;
    endfunction

    // First stored mode within the radius wins; otherwise the point is appended if room is left.
    task automatic classify_point(input t_point pt, output t_merge_result res);
        longint unsigned limit;
        bit              hit;
        limit       = longint'(radius_q) * longint'(radius_q);
        hit         = 1'b0;
        res.mode    = pt;
        res.index   = '0;
        res.created = 1'b0;
        res.full    = 1'b0;
        for (int m = 0; m < int'(count_q) && !hit; m++) begin
            if (dist_sq(pt, modes_q[m]) <= limit) begin
                hit       = 1'b1;
                res.mode  = modes_q[m];
                res.index = IDX_W'(m);
            end
        end
        if (!hit) begin
            if (count_q < MAX_MODES) begin
                modes_q[count_q] = pt;
                res.index        = IDX_W'(count_q);
                res.created      = 1'b1;
                count_q++;
            end else begin
                res.full = 1'b1;
            end
        end
        res.in_use = CNT_W'(count_q);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            o_fail_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_merge_result want;
        if (!i_rst_n) begin
            radius_q = RESET_RADIUS;
            count_q  = 0;
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $error("result transaction with no expected result waiting");
                end else begin
                    want = expected_results.pop_front();
                    check_field("mode_0", want.mode[0], m_axis_tdata[15:0]);
                    check_field("mode_1", want.mode[1], m_axis_tdata[31:16]);
                    check_field("mode_2", want.mode[2], m_axis_tdata[47:32]);
                    check_field("cluster_index", want.index, m_axis_tdata[53:48]);
                    check_field("modes_in_use", want.in_use, m_axis_tdata[60:54]);
                    check_field("tdata padding", '0, m_axis_tdata[63:61]);
                    check_field("created_new", want.created, m_axis_tuser[0]);
                    check_field("table_full", want.full, m_axis_tuser[1]);
                end
            end
            // The block decodes the register from address bit 2; writes elsewhere are ignored.
            if (psel && penable && pwrite && pready && paddr[2] == RADIUS_ADDR[2])
                radius_q = pwdata[RAD_W-1:0];
            if (s_axis_tvalid && s_axis_tready) begin
                classify_point(s_axis_tdata, want);
                expected_results.push_back(want);
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

>>> tb/sv/tb_cluster_mode_merge_table_unit.sv
// Testbench top for the cluster mode merge table: clock, reset, stimulus and verdict.
module tb_cluster_mode_merge_table_unit;
    import cmmt_pkg::*;

    localparam logic [2:0] RADIUS_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR  = 3'd4;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 322;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    t_point      s_axis_tdata;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    wire  [63:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    int     fail_count;
    int     outstanding;
    bit     calm = 1'b0;
    bit     hold_go = 1'b0;
    bit     hold_done = 1'b0;
    t_point sent_points [$];

    cluster_mode_merge_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cmmt_merge_checker #(.RADIUS_ADDR(RADIUS_ADDR)) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("cluster_mode_merge_table_unit test failed");
        $finish;
    end

    // Receiver: bursts of stalls, one long hold-off on request, and none in the calm part.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_go && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    end

    function automatic t_point mk_point(input logic [15:0] c0, input logic [15:0] c1,
                                        input logic [15:0] c2);
        return {c2, c1, c0};
    endfunction

    // Half the points are repeats and near neighbours of earlier points, so that merges happen often.
    function automatic t_point pick_point(input logic [RAD_W-1:0] radius);
        t_point p;
        int     sel;
        int     span;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            p = sent_points[$urandom_range(0, sent_points.size() - 1)];
        end else if (sel < 50) begin
            p    = sent_points[$urandom_range(0, sent_points.size() - 1)];
            span = int'(radius) / $urandom_range(1, 2) + 2;
            for (int k = 0; k < NUM_DIMS; k++)
                p[k] = p[k] + 16'($urandom_range(0, 2 * span) - span);
        end else if (sel < 60) begin
            for (int k = 0; k < NUM_DIMS; k++) begin
                case ($urandom_range(0, 4))
                    0:       p[k] = 16'h8000;
                    1:       p[k] = 16'h7FFF;
                    2:       p[k] = 16'h0000;
                    3:       p[k] = 16'hFFFF;
                    default: p[k] = 16'h0001;
                endcase
            end
        end else begin
            p = t_point'({$urandom, $urandom});
        end
        return p;
    endfunction

    task automatic send_point(input t_point p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tdata  <= p;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_points.push_back(p);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [RAD_W-1:0] radius;
        i_rst_n       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Radius after reset is 0.5: boundary distance, a tie and the coordinate extremes.
        send_point(mk_point(16'h0000, 16'h0000, 16'h0000));
        send_point(mk_point(16'h0080, 16'h0000, 16'h0000));
        send_point(mk_point(16'h0081, 16'h0000, 16'h0000));
        send_point(mk_point(16'h0040, 16'h0040, 16'h0040));
        send_point(mk_point(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_point(mk_point(16'h8000, 16'h8000, 16'h8000));
        send_point(mk_point(16'h8000, 16'h7FFF, 16'h0001));
        send_point(mk_point(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_point(mk_point(16'hFFFF, 16'hFFFF, 16'hFFFF));

        // A write to an unused address must leave the radius alone.
        wait_idle();
        reg_write(SPARE_ADDR, 32'h0000_0000);
        send_point(mk_point(16'h0080, 16'h0000, 16'h0000));

        // Zero radius: only exact copies merge.
        wait_idle();
        reg_write(RADIUS_ADDR, 32'h0000_0000);
        send_point(mk_point(16'h0000, 16'h0000, 16'h0001));
        send_point(mk_point(16'h0000, 16'h0000, 16'h0000));
        send_point(mk_point(16'h0081, 16'h0000, 16'h0000));

        // Largest radius: the far corners still fall within reach of the origin mode.
        wait_idle();
        reg_write(RADIUS_ADDR, 32'h0000_FFFF);
        send_point(mk_point(16'h8000, 16'h8000, 16'h8000));
        send_point(mk_point(16'h7FFF, 16'h8000, 16'h7FFF));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       radius = RAD_W'(256);
                1:       radius = '0;
                2:       radius = RAD_W'(2048);
                3:       radius = '1;
                4:       radius = RAD_W'($urandom_range(0, 4095));
                default: radius = RAD_W'(128);
            endcase
            reg_write(RADIUS_ADDR, {16'($urandom), radius});
            calm = (ph == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 3)
                    hold_go <= 1'b1;
                // Let every outstanding transaction complete before carrying on.
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_idle();
                send_point(pick_point(radius));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("cluster_mode_merge_table_unit test passed");
        end else begin
            $display("cluster_mode_merge_table_unit test failed");
        end
        $finish;
    end

endmodule
